// File: rtl/aavr_pkg.sv
// Shared constants for the axis-angle vector rotation block.
`default_nettype none

package aavr_pkg;

    // Default component width of the vector fields
    localparam int COMPONENT_WIDTH_DEF = 32;

    // Configuration register width and index width
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Q2.30 coefficient fraction bits and the round-half-up offset
    localparam int FRAC = 30;
    localparam int HALF = 1 << (FRAC - 1);

    // Bits of the length-correction scale
    localparam int QW = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Z        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_ANGLE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MINUS_COS = 3'd5;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_AXIS_X        = 32'h0000_0000;
    localparam logic [CFG_W-1:0] RST_AXIS_Y        = 32'h0000_0000;
    localparam logic [CFG_W-1:0] RST_AXIS_Z        = 32'h4000_0000;
    localparam logic [CFG_W-1:0] RST_COS_ANGLE     = 32'h4000_0000;
    localparam logic [CFG_W-1:0] RST_SIN_ANGLE     = 32'h0000_0000;
    localparam logic [CFG_W-1:0] RST_ONE_MINUS_COS = 32'h0000_0000;

endpackage

`default_nettype wire

// File: rtl/axis_angle_vector_rotation.sv
// Top level: axis-angle rotation of a vector stream with length correction.
//
//  channel   | dir | fields (lowest bit up)                      | handshake
//  s_axis    | in  | tdata: vec_x, vec_y, vec_z                  | tvalid/tready
//  m_axis    | out | tdata: rot_x, rot_y, rot_z; tuser: saturated| tvalid/tready
//  cfg write | in  | i_cfg_index, i_cfg_wdata                     | i_cfg_wr_en
//
// One vector per cycle enters while no result waits stalled at m_axis.
// The pipeline is made of the 32-stage scale search, five multiplies in
// series and five add, round and clip levels.
// The whole pipeline holds while a result waits at m_axis with tready low.
// Synchronous active-low reset clears valid bits and loads register defaults.
`default_nettype none

module axis_angle_vector_rotation
    import aavr_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
)
(
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // vec_x, vec_y, vec_z
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    // rot_x, rot_y, rot_z
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    output logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // saturated
    output logic [0:0]                                 m_axis_tuser,
    input  logic                                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                       i_cfg_index,
    input  logic [CFG_W-1:0]                           i_cfg_wdata
);

    localparam int CW   = COMPONENT_WIDTH;
    localparam int BUSW = ((3 * CW + 7) / 8) * 8;
    localparam int LAT  = 47;

    // datapath widths
    localparam int XW   = CW + 2;          // rounded a*v and c*v
    localparam int DW   = CW + 4;          // dot product
    localparam int CRW  = CW + 3;          // cross product
    localparam int ADW  = CW + 5;          // a*(a.v)
    localparam int CSW  = CW + 4;          // cross * sin
    localparam int OW   = CW + 7;          // a*(a.v)*(1-cos)
    localparam int RW   = CW + 8;          // rotated component
    localparam int FW   = CW + 10;         // scaled component
    localparam int M0W  = 2 * CW + 2;
    localparam int M1W  = 2 * RW + 2;
    localparam int PA   = CFG_W + CW;
    localparam int PC   = CFG_W + DW;
    localparam int PS   = CRW + CFG_W;
    localparam int PE   = ADW + CFG_W + 1;
    localparam int PI   = RW + QW + 1;
    localparam int SW   = 3 * RW + 1;

    // configuration registers
    logic signed [CFG_W-1:0] r_ax [3];
    logic signed [CFG_W-1:0] r_cos;
    logic signed [CFG_W-1:0] r_sin;
    logic        [CFG_W-1:0] r_omc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax[0] <= RST_AXIS_X;
            r_ax[1] <= RST_AXIS_Y;
            r_ax[2] <= RST_AXIS_Z;
            r_cos   <= RST_COS_ANGLE;
            r_sin   <= RST_SIN_ANGLE;
            r_omc   <= RST_ONE_MINUS_COS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_AXIS_X:        r_ax[0] <= i_cfg_wdata;
                CFG_AXIS_Y:        r_ax[1] <= i_cfg_wdata;
                CFG_AXIS_Z:        r_ax[2] <= i_cfg_wdata;
                CFG_COS_ANGLE:     r_cos   <= i_cfg_wdata;
                CFG_SIN_ANGLE:     r_sin   <= i_cfg_wdata;
                CFG_ONE_MINUS_COS: r_omc   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control: one valid bit per level, whole pipe holds on stall
    logic [LAT-1:0] r_vld;
    logic           w_ce;

    assign w_ce          = ~r_vld[LAT-1] | m_axis_tready;
    assign s_axis_tready = w_ce;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // input unpack
    logic signed [CW-1:0] w_v [3];
    for (genvar i = 0; i < 3; i++) begin : g_in
        assign w_v[i] = s_axis_tdata[i*CW +: CW];
    end

    // levels 1-2: a_i*v_j, cos*v_i, v_i^2
    logic signed [PA-1:0]     w_pa_p [3][3];
    logic signed [PA-1:0]     w_vc_p [3];
    logic signed [2*CW-1:0]   w_sq0  [3];
    logic signed [XW-1:0]     w_pa   [3][3];
    logic signed [XW-1:0]     w_vc   [3];

    for (genvar i = 0; i < 3; i++) begin : g_la
        for (genvar j = 0; j < 3; j++) begin : g_lb
            aavr_mul #(.AW(CFG_W), .BW(CW)) u_mul_av (
                .i_clk(i_clk), .i_ce(w_ce), .i_a(r_ax[i]), .i_b(w_v[j]),
                .o_p(w_pa_p[i][j])
            );
        end
        aavr_mul #(.AW(CFG_W), .BW(CW)) u_mul_vc (
            .i_clk(i_clk), .i_ce(w_ce), .i_a(r_cos), .i_b(w_v[i]), .o_p(w_vc_p[i])
        );
        aavr_mul #(.AW(CW), .BW(CW)) u_mul_sq (
            .i_clk(i_clk), .i_ce(w_ce), .i_a(w_v[i]), .i_b(w_v[i]), .o_p(w_sq0[i])
        );
    end

    // round half up, dropping the Q2.30 fraction bits
    always_comb begin
        logic [PA-1:0] t;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                t           = w_pa_p[i][j] + PA'(HALF);
                w_pa[i][j]  = t[FRAC +: XW];
            end
            t       = w_vc_p[i] + PA'(HALF);
            w_vc[i] = t[FRAC +: XW];
        end
    end

    // level 3: dot, cross, |v|^2
    logic signed [DW-1:0]  r_d;
    logic signed [CRW-1:0] r_cr [3];
    logic signed [XW-1:0]  r_vc [3];
    logic        [M0W-1:0] r_m0;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_d     <= DW'(w_pa[0][0]) + DW'(w_pa[1][1]) + DW'(w_pa[2][2]);
            r_cr[0] <= CRW'(w_pa[1][2]) - CRW'(w_pa[2][1]);
            r_cr[1] <= CRW'(w_pa[2][0]) - CRW'(w_pa[0][2]);
            r_cr[2] <= CRW'(w_pa[0][1]) - CRW'(w_pa[1][0]);
            r_m0    <= M0W'(w_sq0[0]) + M0W'(w_sq0[1]) + M0W'(w_sq0[2]);
            for (int i = 0; i < 3; i++) begin
                r_vc[i] <= w_vc[i];
            end
        end
    end

    // levels 4-5: a_i*d and cross_i*sin
    logic signed [PC-1:0]  w_ad_p [3];
    logic signed [PS-1:0]  w_cs_p [3];
    logic signed [ADW-1:0] w_ad   [3];
    logic signed [CSW-1:0] w_cs   [3];

    for (genvar i = 0; i < 3; i++) begin : g_lc
        aavr_mul #(.AW(CFG_W), .BW(DW)) u_mul_ad (
            .i_clk(i_clk), .i_ce(w_ce), .i_a(r_ax[i]), .i_b(r_d), .o_p(w_ad_p[i])
        );
        aavr_mul #(.AW(CRW), .BW(CFG_W)) u_mul_cs (
            .i_clk(i_clk), .i_ce(w_ce), .i_a(r_cr[i]), .i_b(r_sin), .o_p(w_cs_p[i])
        );
    end

    always_comb begin
        logic [PC-1:0] tc;
        logic [PS-1:0] ts;
        for (int i = 0; i < 3; i++) begin
            tc      = w_ad_p[i] + PC'(HALF);
            w_ad[i] = tc[FRAC +: ADW];
            ts      = w_cs_p[i] + PS'(HALF);
            w_cs[i] = ts[FRAC +: CSW];
        end
    end

    // level 6: rounded a*(a.v)
    logic signed [ADW-1:0] r_ad [3];
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_ad[i] <= w_ad[i];
            end
        end
    end

    // levels 7-8: times (1 - cos); side terms delayed to level 8
    logic signed [CFG_W:0] w_omc;
    logic signed [PE-1:0]  w_om_p [3];
    logic signed [OW-1:0]  w_om   [3];
    logic signed [XW-1:0]  w_vc_d [3];
    logic signed [CSW-1:0] w_cs_d [3];

    assign w_omc = {1'b0, r_omc};

    for (genvar i = 0; i < 3; i++) begin : g_le
        aavr_mul #(.AW(ADW), .BW(CFG_W + 1)) u_mul_om (
            .i_clk(i_clk), .i_ce(w_ce), .i_a(r_ad[i]), .i_b(w_omc), .o_p(w_om_p[i])
        );
        aavr_dly #(.W(XW), .N(5)) u_dly_vc (
            .i_clk(i_clk), .i_ce(w_ce), .i_d(r_vc[i]), .o_q(w_vc_d[i])
        );
        aavr_dly #(.W(CSW), .N(3)) u_dly_cs (
            .i_clk(i_clk), .i_ce(w_ce), .i_d(w_cs[i]), .o_q(w_cs_d[i])
        );
    end

    always_comb begin
        logic [PE-1:0] te;
        for (int i = 0; i < 3; i++) begin
            te      = w_om_p[i] + PE'(HALF);
            w_om[i] = te[FRAC +: OW];
        end
    end

    // level 9: rotated vector
    logic signed [RW-1:0] r_r [3];
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_r[i] <= RW'(w_om[i]) + RW'(w_vc_d[i]) + RW'(w_cs_d[i]);
            end
        end
    end

    // levels 10-11: squares of the rotated vector
    logic signed [2*RW-1:0] w_sq1 [3];
    logic        [3*RW-1:0] w_r_d;
    logic        [M0W-1:0]  w_m0_d;

    for (genvar i = 0; i < 3; i++) begin : g_lg
        aavr_mul #(.AW(RW), .BW(RW)) u_mul_sq1 (
            .i_clk(i_clk), .i_ce(w_ce), .i_a(r_r[i]), .i_b(r_r[i]), .o_p(w_sq1[i])
        );
    end

    aavr_dly #(.W(3 * RW), .N(2)) u_dly_r (
        .i_clk(i_clk), .i_ce(w_ce), .i_d({r_r[2], r_r[1], r_r[0]}), .o_q(w_r_d)
    );
    aavr_dly #(.W(M0W), .N(8)) u_dly_m0 (
        .i_clk(i_clk), .i_ce(w_ce), .i_d(r_m0), .o_q(w_m0_d)
    );

    // level 12: |v'|^2
    logic [M1W-1:0]  r_m1;
    logic [M0W-1:0]  r_m0h;
    logic [3*RW-1:0] r_rh;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_m1  <= M1W'(w_sq1[0]) + M1W'(w_sq1[1]) + M1W'(w_sq1[2]);
            r_m0h <= w_m0_d;
            r_rh  <= w_r_d;
        end
    end

    // levels 13-44: scale search, rotated vector and zero flag ride along
    logic [QW-1:0] w_q;
    logic [SW-1:0] w_side_q;

    aavr_isqrt #(.M0W(M0W), .M1W(M1W), .SW(SW)) u_isqrt (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_m0   (r_m0h),
        .i_m1   (r_m1),
        .i_side ({(r_m1 == '0), r_rh}),
        .o_q    (w_q),
        .o_side (w_side_q)
    );

    // levels 45-46: r_i * q
    logic signed [QW:0]   w_qs;
    logic signed [RW-1:0] w_rq [3];
    logic signed [PI-1:0] w_fp [3];
    logic        [SW-1:0] w_side_f;

    assign w_qs = {1'b0, w_q};

    for (genvar i = 0; i < 3; i++) begin : g_li
        assign w_rq[i] = w_side_q[i*RW +: RW];
        aavr_mul #(.AW(RW), .BW(QW + 1)) u_mul_q (
            .i_clk(i_clk), .i_ce(w_ce), .i_a(w_rq[i]), .i_b(w_qs), .o_p(w_fp[i])
        );
    end

    aavr_dly #(.W(SW), .N(2)) u_dly_side (
        .i_clk(i_clk), .i_ce(w_ce), .i_d(w_side_q), .o_q(w_side_f)
    );

    // level 47: round, pick unscaled on zero length, clip to component range
    logic [CW-1:0] n_out [3];
    logic          n_sat;
    logic [CW-1:0] r_out [3];
    logic          r_sat;

    always_comb begin
        logic [PI-1:0]        t;
        logic signed [FW-1:0] sel;
        logic [FW-CW:0]       hib;
        n_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            t   = w_fp[i] + PI'(HALF);
            sel = w_side_f[SW-1] ? FW'($signed(w_side_f[i*RW +: RW])) : t[FRAC +: FW];
            hib = sel[FW-1:CW-1];
            if ((&hib) | ~(|hib)) begin
                n_out[i] = sel[CW-1:0];
            end else if (sel[FW-1]) begin
                n_out[i] = {1'b1, {(CW-1){1'b0}}};
                n_sat    = 1'b1;
            end else begin
                n_out[i] = {1'b0, {(CW-1){1'b1}}};
                n_sat    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_sat <= n_sat;
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= n_out[i];
            end
        end
    end

    assign m_axis_tdata = BUSW'({r_out[2], r_out[1], r_out[0]});
    assign m_axis_tuser = r_sat;

endmodule

`default_nettype wire

// File: rtl/aavr_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
`default_nettype none

module aavr_mul
    import aavr_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 32
)
(
    input  logic                     i_clk,
    input  logic                     i_ce,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-1:0]  o_p
);

    localparam int PW = AW + BW;
    localparam int HA = AW / 2;
    localparam int HB = BW / 2;

    logic signed [AW-HA-1:0]      w_a_hi;
    logic signed [HA:0]           w_a_lo;
    logic signed [BW-HB-1:0]      w_b_hi;
    logic signed [HB:0]           w_b_lo;

    logic signed [AW-HA+BW-HB-1:0] r_hh;
    logic signed [AW-HA+HB:0]      r_hl;
    logic signed [HA+BW-HB:0]      r_lh;
    logic signed [HA+HB+1:0]       r_ll;
    logic signed [PW-1:0]          r_p;

    // low halves are unsigned, carried with a zero sign bit
    assign w_a_hi = i_a[AW-1:HA];
    assign w_a_lo = {1'b0, i_a[HA-1:0]};
    assign w_b_hi = i_b[BW-1:HB];
    assign w_b_lo = {1'b0, i_b[HB-1:0]};

    // stage 1: partial products
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_hh <= w_a_hi * w_b_hi;
            r_hl <= w_a_hi * w_b_lo;
            r_lh <= w_a_lo * w_b_hi;
            r_ll <= w_a_lo * w_b_lo;
        end
    end

    // stage 2: aligned sum
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p <= (PW'(r_hh) <<< (HA + HB)) + (PW'(r_hl) <<< HA)
                 + (PW'(r_lh) <<< HB) + PW'(r_ll);
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// File: rtl/aavr_dly.sv
// Enabled delay line of fixed depth for data that rides beside the datapath.
`default_nettype none

module aavr_dly
    import aavr_pkg::*;
#(
    parameter int W = 1,
    parameter int N = 1
)
(
    input  logic         i_clk,
    input  logic         i_ce,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [N];

    // shift one tap per enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_pipe[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    assign o_q = r_pipe[N-1];

endmodule

`default_nettype wire

// File: rtl/aavr_isqrt.sv
// Pipelined search for the largest q with q*q*m1 <= m0*2^60, one bit per stage.
`default_nettype none

module aavr_isqrt
    import aavr_pkg::*;
#(
    parameter int M0W = 66,
    parameter int M1W = 82,
    parameter int SW  = 1
)
(
    input  logic           i_clk,
    input  logic           i_ce,
    input  logic [M0W-1:0] i_m0,
    input  logic [M1W-1:0] i_m1,
    input  logic [SW-1:0]  i_side,
    output logic [QW-1:0]  o_q,
    output logic [SW-1:0]  o_side
);

    // remainder width covers the largest trial term (qm << 32) + (m1 << 62)
    localparam int W   = M1W + 2 * QW + 3;
    localparam int QMW = M1W + QW;

    logic [W-1:0]   s_rem  [QW+1];
    logic [QMW-1:0] s_qm   [QW+1];
    logic [QW-1:0]  s_q    [QW+1];
    logic [M1W-1:0] s_m1   [QW+1];
    logic [SW-1:0]  s_side [QW+1];

    logic [W-1:0]   r_rem  [QW];
    logic [QMW-1:0] r_qm   [QW];
    logic [QW-1:0]  r_q    [QW];
    logic [M1W-1:0] r_m1   [QW];
    logic [SW-1:0]  r_side [QW];

    // entry: remainder starts at m0 << 60, scale and q*m1 at zero
    assign s_rem[0]  = W'(i_m0) << (2 * FRAC);
    assign s_qm[0]   = '0;
    assign s_q[0]    = '0;
    assign s_m1[0]   = i_m1;
    assign s_side[0] = i_side;

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int B = QW - 1 - j;

        logic [W-1:0] w_try;
        logic         w_take;

        // growth of q*q*m1 when bit B is set
        always_comb begin
            w_try  = (W'(s_qm[j]) << (B + 1)) + (W'(s_m1[j]) << (2 * B));
            w_take = (s_rem[j] >= w_try);
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[j]  <= w_take ? (s_rem[j] - w_try) : s_rem[j];
                r_qm[j]   <= w_take ? (s_qm[j] + (QMW'(s_m1[j]) << B)) : s_qm[j];
                r_q[j]    <= s_q[j] | (QW'(w_take) << B);
                r_m1[j]   <= s_m1[j];
                r_side[j] <= s_side[j];
            end
        end

        assign s_rem[j+1]  = r_rem[j];
        assign s_qm[j+1]   = r_qm[j];
        assign s_q[j+1]    = r_q[j];
        assign s_m1[j+1]   = r_m1[j];
        assign s_side[j+1] = r_side[j];
    end

    assign o_q    = s_q[QW];
    assign o_side = s_side[QW];

endmodule

`default_nettype wire

// File: rtl/aavr_checker.sv
// Port-level checks for the rotation block and their binding to the top level.
`default_nettype none

module aavr_checker
#(
    parameter int COMPONENT_WIDTH = 32
)
(
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    s_axis_tready,
    input logic                                    m_axis_tvalid,
    input logic                                    m_axis_tready,
    input logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
    input logic [0:0]                              m_axis_tuser
);

    localparam int CW = COMPONENT_WIDTH;
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // an empty output stage never blocks new requests
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // a stalled result blocks the input
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // the clip flag implies a component at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[CW-1:0] == CMAX || m_axis_tdata[CW-1:0] == CMIN ||
            m_axis_tdata[2*CW-1:CW] == CMAX || m_axis_tdata[2*CW-1:CW] == CMIN ||
            m_axis_tdata[3*CW-1:2*CW] == CMAX || m_axis_tdata[3*CW-1:2*CW] == CMIN)
        else $error("clip flag without clipped component");

endmodule

bind axis_angle_vector_rotation aavr_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_aavr_chk (.*);

`default_nettype wire
